// File: design/braced_command_byte_parser_top_assert.svh
// Assertion macros for the braced command byte parser checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef BRACED_COMMAND_BYTE_PARSER_TOP_ASSERT_SVH
`define BRACED_COMMAND_BYTE_PARSER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define BCBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define BCBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bcbp_pkg.sv
// Shared types and constants for the braced command byte parser.
// No dependencies; used by the controller, datapath, top and checker.
package bcbp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 32;
    localparam int ACC_WIDTH_DEF     = 32;

    localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] KIND_PWM   = 3'd0;
    localparam logic [2:0] KIND_FREQ  = 3'd1;
    localparam logic [2:0] KIND_DAC   = 3'd2;
    localparam logic [2:0] KIND_ACCEL = 3'd3;
    localparam logic [2:0] KIND_NRF   = 3'd4;
    localparam logic [2:0] KIND_GPIO  = 3'd5;
    localparam logic [2:0] KIND_RESET = 3'd6;
    localparam logic [2:0] KIND_TEST  = 3'd7;

    // datapath -> controller
    typedef struct packed {
        logic       is_open;    // byte is '{'
        logic       is_close;   // byte is '}'
        logic       is_digit;   // '0'..'9'
        logic       chan_ok;    // 'a'..'d'
        logic       kind_hit;   // byte names a command kind
        logic [2:0] kind;       // that kind
        logic       chan_zero;  // no pwm channel taken yet
        logic       fill_zero;  // nrf buffer empty
        logic       out_last;   // result register holds the final word
    } t_dp_stat;

    // controller -> datapath
    typedef struct packed {
        logic       clear;       // end of command: drop per-command state
        logic       take_chan;
        logic       take_digit;
        logic       take_byte;   // gpio / test keep the byte
        logic       take_reset;
        logic       push;        // nrf byte into buffer
        logic       load_single; // load one-word result
        logic       load_nrf;    // load next buffered byte as result
        logic       rd_next;
        logic [2:0] kind;
    } t_dp_cmd;

endpackage

// File: design/bcbp_ctrl.sv
// Parser controller: brace framing, kind selection, nesting and result sequencing.
// Depends on bcbp_pkg; drives bcbp_dp through t_dp_cmd.
module bcbp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bcbp_pkg::t_dp_stat i_stat,
    output bcbp_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_BODY,
        S_EMIT,
        S_NRF_RD,
        S_NRF_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_kind, n_kind;
    logic [7:0] r_nest, n_nest;
    logic       in_acc;
    logic       bad;

    assign o_in_ready  = (r_state == S_IDLE) || (r_state == S_HEAD) || (r_state == S_BODY);
    assign o_out_valid = (r_state == S_EMIT) || (r_state == S_NRF_EMIT);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_nest  = r_nest;
        bad     = 1'b0;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_stat.is_open) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (in_acc) begin
                    if (i_stat.is_close) begin
                        // empty command, nothing to report
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end else if (i_stat.kind_hit) begin
                        n_kind  = i_stat.kind;
                        n_state = S_BODY;
                    end
                end
            end
            S_BODY: begin
                if (in_acc) begin
                    if (i_stat.is_close && (r_nest == 8'd0)) begin
                        if ((r_kind == bcbp_pkg::KIND_NRF) && !i_stat.fill_zero) begin
                            n_state = S_NRF_RD;
                        end else begin
                            o_cmd.load_single = 1'b1;
                            o_cmd.clear       = 1'b1;
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_nest = r_nest + {7'd0, i_stat.is_open} - {7'd0, i_stat.is_close};
                        case (r_kind)
                            bcbp_pkg::KIND_PWM: begin
                                if (i_stat.chan_zero) begin
                                    o_cmd.take_chan = i_stat.chan_ok;
                                    bad = !i_stat.chan_ok;
                                end else begin
                                    o_cmd.take_digit = i_stat.is_digit;
                                    bad = !i_stat.is_digit;
                                end
                            end
                            bcbp_pkg::KIND_FREQ, bcbp_pkg::KIND_DAC: begin
                                o_cmd.take_digit = i_stat.is_digit;
                                bad = !i_stat.is_digit;
                            end
                            bcbp_pkg::KIND_NRF:   o_cmd.push = 1'b1;
                            bcbp_pkg::KIND_GPIO,
                            bcbp_pkg::KIND_TEST:  o_cmd.take_byte = 1'b1;
                            bcbp_pkg::KIND_RESET: o_cmd.take_reset = 1'b1;
                            default: ;
                        endcase
                        if (bad) begin
                            // silent abort
                            o_cmd.clear = 1'b1;
                            n_nest  = 8'd0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_NRF_RD: begin
                o_cmd.load_nrf = 1'b1;
                n_state = S_NRF_EMIT;
            end
            S_NRF_EMIT: begin
                if (i_out_ready) begin
                    if (i_stat.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state = S_NRF_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= bcbp_pkg::KIND_PWM;
            r_nest  <= 8'd0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_nest  <= n_nest;
        end
    end

endmodule

// File: design/bcbp_dp.sv
// Parser datapath: byte decode, decimal accumulator, kept bytes, nrf buffer, result register.
// Depends on bcbp_pkg; steered by bcbp_ctrl.
module bcbp_dp #(
    parameter int PAYLOAD_DEPTH = bcbp_pkg::PAYLOAD_DEPTH_DEF,
    parameter int ACC_WIDTH     = bcbp_pkg::ACC_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [7:0]                         i_in_byte,
    input  bcbp_pkg::t_dp_cmd                  i_cmd,
    output bcbp_pkg::t_dp_stat                 o_stat,
    output logic [2:0]                         o_cmd_kind,
    output logic [2:0]                         o_channel,
    output logic [31:0]                        o_value,
    output logic [$clog2(PAYLOAD_DEPTH+1)-1:0] o_payload_count,
    output logic                               o_last
);

    localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
    localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic [ACC_WIDTH-1:0]    r_acc;
    logic [ACC_WIDTH-1:0]    acc_digit;
    logic [ACC_WIDTH+31:0]   acc_ext;
    logic [2:0]              r_chan;
    logic [7:0]              r_byte;
    logic [7:0]              r_reset_val;
    logic [CNT_W-1:0]        r_fill;
    logic [CNT_W-1:0]        r_rd_idx;
    logic [7:0]              mem [PAYLOAD_DEPTH];
    logic [31:0]             single_val;

    // byte decode
    always_comb begin
        o_stat          = '0;
        o_stat.is_open  = (i_in_byte == bcbp_pkg::CH_LBRACE);
        o_stat.is_close = (i_in_byte == bcbp_pkg::CH_RBRACE);
        o_stat.is_digit = (i_in_byte >= bcbp_pkg::CH_ZERO) && (i_in_byte <= bcbp_pkg::CH_NINE);
        o_stat.chan_ok  = (i_in_byte >= bcbp_pkg::CH_A) && (i_in_byte <= bcbp_pkg::CH_D);
        o_stat.kind_hit = 1'b1;
        case (i_in_byte)
            bcbp_pkg::CH_P:     o_stat.kind = bcbp_pkg::KIND_PWM;
            bcbp_pkg::CH_F:     o_stat.kind = bcbp_pkg::KIND_FREQ;
            bcbp_pkg::CH_D:     o_stat.kind = bcbp_pkg::KIND_DAC;
            bcbp_pkg::CH_A:     o_stat.kind = bcbp_pkg::KIND_ACCEL;
            bcbp_pkg::CH_N:     o_stat.kind = bcbp_pkg::KIND_NRF;
            bcbp_pkg::CH_G:     o_stat.kind = bcbp_pkg::KIND_GPIO;
            bcbp_pkg::CH_R:     o_stat.kind = bcbp_pkg::KIND_RESET;
            bcbp_pkg::CH_SLASH: o_stat.kind = bcbp_pkg::KIND_TEST;
            default: begin
                o_stat.kind     = bcbp_pkg::KIND_PWM;
                o_stat.kind_hit = 1'b0;
            end
        endcase
        o_stat.chan_zero = (r_chan == 3'd0);
        o_stat.fill_zero = (r_fill == '0);
        o_stat.out_last  = o_last;
    end

    // acc*10 + digit as two shifts and adds, wraps at ACC_WIDTH
    assign acc_digit = (r_acc << 3) + (r_acc << 1) + ACC_WIDTH'(i_in_byte[3:0]);
    assign acc_ext   = {32'd0, r_acc};

    always_comb begin
        case (i_cmd.kind)
            bcbp_pkg::KIND_PWM,
            bcbp_pkg::KIND_FREQ,
            bcbp_pkg::KIND_DAC:   single_val = acc_ext[31:0];
            bcbp_pkg::KIND_GPIO,
            bcbp_pkg::KIND_TEST:  single_val = {24'd0, r_byte};
            bcbp_pkg::KIND_RESET: single_val = {24'd0, r_reset_val};
            default:              single_val = 32'd0;
        endcase
    end

    // per-command state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_chan      <= 3'd0;
            r_byte      <= 8'd0;
            r_reset_val <= 8'd0;
            r_fill      <= '0;
            r_rd_idx    <= '0;
        end else begin
            if (i_cmd.take_reset) r_reset_val <= i_in_byte;
            if (i_cmd.clear) begin
                r_acc    <= '0;
                r_chan   <= 3'd0;
                r_byte   <= 8'd0;
                r_fill   <= '0;
                r_rd_idx <= '0;
            end else begin
                if (i_cmd.take_digit) r_acc <= acc_digit;
                if (i_cmd.take_chan)  r_chan <= i_in_byte[2:0];  // 'a'..'d' -> 1..4
                if (i_cmd.take_byte)  r_byte <= i_in_byte;
                if (i_cmd.push && (r_fill < CNT_W'(PAYLOAD_DEPTH))) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
                if (i_cmd.rd_next) r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
        end
    end

    // nrf buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_fill < CNT_W'(PAYLOAD_DEPTH))) begin
            mem[r_fill[IDX_W-1:0]] <= i_in_byte;
        end
    end

    // result register, read port of the buffer lands here
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            o_cmd_kind      <= i_cmd.kind;
            o_channel       <= (i_cmd.kind == bcbp_pkg::KIND_PWM) ? r_chan : 3'd0;
            o_value         <= single_val;
            o_payload_count <= '0;
            o_last          <= 1'b1;
        end else if (i_cmd.load_nrf) begin
            o_cmd_kind      <= bcbp_pkg::KIND_NRF;
            o_channel       <= 3'd0;
            o_value         <= {24'd0, mem[r_rd_idx[IDX_W-1:0]]};
            o_payload_count <= r_fill;
            o_last          <= ((r_rd_idx + CNT_W'(1)) == r_fill);
        end
    end

endmodule

// File: design/braced_command_byte_parser_top.sv
// Top level of the braced command byte parser.
// Depends on bcbp_pkg, bcbp_ctrl and bcbp_dp.
//
// Parses serial bytes into braced commands such as {pa1000}. Bytes outside
// braces are dropped until a '{'. The first kind letter after it picks the
// command: p pwm, f freq, d dac, a accel, n nrf, g gpio, r reset, / test.
// pwm takes a channel a-d then decimal digits; freq and dac take digits
// (accumulated modulo 2^ACC_WIDTH, low 32 bits reported); nrf buffers up to
// PAYLOAD_DEPTH raw bytes; gpio, reset and test keep the last byte (the
// reset byte survives across commands). Inner braces are counted; a bad
// byte silently drops the command. The '}' at depth zero reports it.
// Timing: while a command is being parsed one input word is taken every
// cycle. On the closing brace input stalls until the result words are
// taken. For each buffered byte of an nrf run the buffer is first read into
// the result register, then the word is handed over, held by any output
// backpressure. The buffer needs no clearing pass; its fill count bounds
// every read.
module braced_command_byte_parser_top #(
    parameter int PAYLOAD_DEPTH = bcbp_pkg::PAYLOAD_DEPTH_DEF,
    parameter int ACC_WIDTH     = bcbp_pkg::ACC_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input byte stream
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_in_byte,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [2:0]                         o_cmd_kind,
    output logic [2:0]                         o_channel,
    output logic [31:0]                        o_value,
    output logic [$clog2(PAYLOAD_DEPTH+1)-1:0] o_payload_count,
    output logic                               o_last
);

    bcbp_pkg::t_dp_cmd  dp_cmd;
    bcbp_pkg::t_dp_stat dp_stat;

    // framing, nesting and result sequencing
    bcbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // decode, accumulators, nrf buffer and the result register
    bcbp_dp #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .ACC_WIDTH     (ACC_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_cmd_kind      (o_cmd_kind),
        .o_channel       (o_channel),
        .o_value         (o_value),
        .o_payload_count (o_payload_count),
        .o_last          (o_last)
    );

endmodule

// File: design/bcbp_chk.sv
// Port-level checker for the braced command byte parser, bound to the top level.
// Depends on bcbp_pkg and braced_command_byte_parser_top_assert.svh.
`include "braced_command_byte_parser_top_assert.svh"

module bcbp_chk #(
    parameter int PAYLOAD_DEPTH = bcbp_pkg::PAYLOAD_DEPTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [2:0]                         o_cmd_kind,
    input logic [2:0]                         o_channel,
    input logic [31:0]                        o_value,
    input logic [$clog2(PAYLOAD_DEPTH+1)-1:0] o_payload_count,
    input logic                               o_last
);

    // a stalled result word holds
    `BCBP_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_value) && $stable(o_last), "result word changed while stalled")

    // no input word taken while a result is pending
    `BCBP_ASSERT_IMP(a_busy_on_out, o_out_valid, !o_in_ready, "input taken during result")

    // a run that is not finished keeps input stalled
    `BCBP_ASSERT_NXT(a_run_busy, o_out_valid && i_out_ready && !o_last, !o_in_ready && !$stable(o_out_valid) || !o_in_ready, "input reopened mid nrf run")

    // channel only on pwm words
    `BCBP_ASSERT_IMP(a_chan_pwm, o_out_valid && (o_cmd_kind != bcbp_pkg::KIND_PWM), o_channel == 3'd0, "channel set on non-pwm word")

    // every non-nrf command is one final word with no count
    `BCBP_ASSERT_IMP(a_single_word, o_out_valid && (o_cmd_kind != bcbp_pkg::KIND_NRF), o_last && (o_payload_count == '0), "non-nrf word not single")

endmodule

bind braced_command_byte_parser_top bcbp_chk #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_bcbp_chk (.*);
